@@ src/rntb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roman numeral converter package
// Shared payload types, the letter and step codes, and the group tables
// used by the front classifier and the back-end parser.
// ----------------------------------------------------------------------------
package rntb_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int GROUP_W             = 3;
    localparam int VALUE_W             = 12;

    // Group index at which every digit group has been closed.
    localparam logic [GROUP_W-1:0] GROUP_DONE = 3'd4;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } rntb_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               bad_numeral;
    } rntb_out_t;

    // Numeral letters after classification; anything else is LTR_NONE.
    typedef enum logic [2:0] {
        LTR_NONE,
        LTR_I,
        LTR_V,
        LTR_X,
        LTR_L,
        LTR_C,
        LTR_D,
        LTR_M
    } letter_t;

    // How a character is consumed by a digit group.
    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_ONE,
        STEP_FIVE,
        STEP_FOUR,
        STEP_NINE
    } step_t;

    // One entry of the queue between the classifier and the parser.
    typedef struct packed {
        letter_t letter;
        logic    last_symbol;
    } rntb_entry_t;

    function automatic letter_t classify(input logic [7:0] symbol);
        letter_t l;
        case (symbol)
            8'h49:   l = LTR_I;
            8'h56:   l = LTR_V;
            8'h58:   l = LTR_X;
            8'h4C:   l = LTR_L;
            8'h43:   l = LTR_C;
            8'h44:   l = LTR_D;
            8'h4D:   l = LTR_M;
            default: l = LTR_NONE;
        endcase
        return l;
    endfunction

    function automatic letter_t grp_one(input logic [1:0] g);
        letter_t l;
        case (g)
            2'd0:    l = LTR_M;
            2'd1:    l = LTR_C;
            2'd2:    l = LTR_X;
            default: l = LTR_I;
        endcase
        return l;
    endfunction

    function automatic letter_t grp_five(input logic [1:0] g);
        letter_t l;
        case (g)
            2'd1:    l = LTR_D;
            2'd2:    l = LTR_L;
            2'd3:    l = LTR_V;
            default: l = LTR_NONE;
        endcase
        return l;
    endfunction

    function automatic letter_t grp_high(input logic [1:0] g);
        letter_t l;
        case (g)
            2'd1:    l = LTR_M;
            2'd2:    l = LTR_C;
            2'd3:    l = LTR_X;
            default: l = LTR_NONE;
        endcase
        return l;
    endfunction

    // Amount added to the running total for a step in group g.
    function automatic logic [VALUE_W-1:0] step_amount(input logic [1:0] g,
                                                       input step_t   s);
        logic [VALUE_W-1:0] w;
        logic [VALUE_W-1:0] a;
        case (g)
            2'd0:    w = 12'd1000;
            2'd1:    w = 12'd100;
            2'd2:    w = 12'd10;
            default: w = 12'd1;
        endcase
        case (s)
            STEP_ONE:  a = w;
            STEP_FIVE: a = (w << 2) + w;
            STEP_FOUR: a = (w << 1) + w;
            STEP_NINE: a = w << 3;
            default:   a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ src/roman_numeral_to_binary_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roman numeral to binary converter, top level
// A final character's result passes through a queue slot and then the parser's result register.
// Throughput: one character per cycle; the parser takes one queue entry each cycle.
// A full queue or a stalled result register holding back a final character stalls input.
// Reset: synchronous, active low; clears the queue, the parse state and result valid.
// ----------------------------------------------------------------------------
module roman_numeral_to_binary_core #(
    parameter int QUEUE_DEPTH = rntb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rntb_pkg::rntb_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rntb_pkg::rntb_out_t m_data
);
    import rntb_pkg::*;

    // Each character is classified as it arrives, so the queue stores only a
    // three-bit letter code and the last-character mark.
    rntb_entry_t front_entry;
    rntb_entry_t head_entry;
    logic        head_valid;
    logic        head_ready;

    rntb_front u_front (
        .in_data   (s_data),
        .out_entry (front_entry)
    );

    // The queue lets the input side keep taking transfers while the parser
    // waits on a stalled result; its depth sets how much slack there is.
    rntb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_entry (front_entry),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_entry  (head_entry)
    );

    // The parser walks the digit groups for one character per cycle and
    // writes the value and error flag into its result register on the last
    // character of a numeral, then returns to the thousands group.
    rntb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (head_valid),
        .in_ready (head_ready),
        .in_entry (head_entry),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ src/rntb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roman numeral converter front end
// Maps each incoming ASCII character onto a numeral letter code.
// ----------------------------------------------------------------------------
module rntb_front (
    input  rntb_pkg::rntb_in_t    in_data,
    output rntb_pkg::rntb_entry_t out_entry
);
    import rntb_pkg::*;

    always_comb begin
        out_entry.letter      = classify(in_data.symbol);
        out_entry.last_symbol = in_data.last_symbol;
    end

endmodule

@@ src/rntb_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roman numeral converter queue
// Small FIFO of classified characters between the front end and the parser.
// ----------------------------------------------------------------------------
module rntb_queue #(
    parameter int DEPTH = rntb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  rntb_pkg::rntb_entry_t push_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output rntb_pkg::rntb_entry_t pop_entry
);
    import rntb_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rntb_entry_t            slot_reg [DEPTH];
    logic [IDX_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ src/rntb_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roman numeral converter parser
// Greedy digit-group parser with a registered result stage.
// ----------------------------------------------------------------------------
module rntb_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rntb_pkg::rntb_entry_t in_entry,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rntb_pkg::rntb_out_t   m_data
);
    import rntb_pkg::*;

    logic [GROUP_W-1:0] group_reg, group_next;
    logic               five_reg, five_next;
    logic [1:0]         ones_reg, ones_next;
    logic [VALUE_W-1:0] total_reg, total_next;
    logic               err_reg, err_next;
    logic               out_valid_reg, out_valid_next;
    rntb_out_t          out_data_reg, out_data_next;
    logic               take;

    // A non-final character never produces a result, so it may pass even
    // while the result register is stalled.
    assign in_ready = !in_entry.last_symbol || !out_valid_reg || m_ready;
    assign take     = in_valid && in_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        step_t              step_v [4];
        logic               found;
        logic [1:0]         g2;
        logic               f;
        logic [1:0]         o;
        logic               started;
        logic [GROUP_W-1:0] grp_sel;
        logic               five_sel;
        logic [1:0]         ones_sel;
        logic [VALUE_W-1:0] amt_sel;

        found    = 1'b0;
        grp_sel  = group_reg;
        five_sel = five_reg;
        ones_sel = ones_reg;
        amt_sel  = '0;

        // Evaluate every group independently; later groups start fresh.
        for (int g = 0; g < 4; g++) begin
            g2      = 2'(g);
            f       = (group_reg == GROUP_W'(g)) ? five_reg : 1'b0;
            o       = (group_reg == GROUP_W'(g)) ? ones_reg : 2'd0;
            started = f || (o != 2'd0);
            step_v[g] = STEP_NONE;
            if (group_reg <= GROUP_W'(g)) begin
                if (g == 0) begin
                    if (in_entry.letter == grp_one(g2) && o != 2'd3) begin
                        step_v[g] = STEP_ONE;
                    end
                end else if (!started && in_entry.letter == grp_five(g2)) begin
                    step_v[g] = STEP_FIVE;
                end else if (in_entry.letter == grp_one(g2) && o != 2'd3) begin
                    step_v[g] = STEP_ONE;
                end else if (o == 2'd1 && !f && in_entry.letter == grp_five(g2)) begin
                    step_v[g] = STEP_FOUR;
                end else if (o == 2'd1 && !f && in_entry.letter == grp_high(g2)) begin
                    step_v[g] = STEP_NINE;
                end
            end
            // The lowest group that takes the character wins.
            if (!found && step_v[g] != STEP_NONE) begin
                found   = 1'b1;
                amt_sel = step_amount(g2, step_v[g]);
                case (step_v[g])
                    STEP_ONE: begin
                        grp_sel  = GROUP_W'(g);
                        five_sel = f;
                        ones_sel = 2'(o + 2'd1);
                    end
                    STEP_FIVE: begin
                        grp_sel  = GROUP_W'(g);
                        five_sel = 1'b1;
                        ones_sel = o;
                    end
                    default: begin
                        grp_sel  = GROUP_W'(g + 1);
                        five_sel = 1'b0;
                        ones_sel = 2'd0;
                    end
                endcase
            end
        end

        group_next     = group_reg;
        five_next      = five_reg;
        ones_next      = ones_reg;
        total_next     = total_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;

        if (take) begin
            if (!err_reg) begin
                if (found) begin
                    group_next = grp_sel;
                    five_next  = five_sel;
                    ones_next  = ones_sel;
                    total_next = total_reg + amt_sel;
                end else begin
                    err_next = 1'b1;
                end
            end
            if (in_entry.last_symbol) begin
                out_valid_next            = 1'b1;
                out_data_next.value       = err_next ? '0 : total_next;
                out_data_next.bad_numeral = err_next;
                group_next                = '0;
                five_next                 = 1'b0;
                ones_next                 = 2'd0;
                total_next                = '0;
                err_next                  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_reg     <= '0;
            five_reg      <= 1'b0;
            ones_reg      <= 2'd0;
            total_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            group_reg     <= group_next;
            five_reg      <= five_next;
            ones_reg      <= ones_next;
            total_reg     <= total_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roman numeral converter testbench
// Streams numerals into roman_numeral_to_binary_core one character per
// transfer. The stimulus mixes well-formed numerals, corrupted numerals and
// random byte noise. A local parser predicts each numeral's value and error
// flag, and every result transfer is checked against the oldest prediction.
// The run steps through several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import rntb_pkg::*;

    // ASCII codes of the numeral letters.
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_V = 8'h56;
    localparam logic [7:0] CH_X = 8'h58;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_M = 8'h4D;

    // Group index at which every digit group is closed.
    localparam logic [2:0] GRP_CLOSED = 3'd4;

    // Cycles without any transfer before the run is declared hung. The long
    // receiver hold-off is well below this.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    rntb_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rntb_out_t m_data;

    roman_numeral_to_binary_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Characters waiting to be offered, and the results still owed by the block.
    rntb_in_t   pending_symbols[$];
    rntb_out_t  expected_numerals[$];
    logic [7:0] numeral_buf[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int fail_count = 0;

    // Shadow of the parser state inside the block.
    logic [2:0]  prs_group = '0;
    logic        prs_five  = 1'b0;
    logic [1:0]  prs_ones  = '0;
    logic [11:0] prs_total = '0;
    logic        prs_bad   = 1'b0;

    // Letter tables of the digit groups: thousands, hundreds, tens, units.
    function automatic logic [7:0] one_letter(input logic [1:0] g);
        case (g)
            2'd0:    return CH_M;
            2'd1:    return CH_C;
            2'd2:    return CH_X;
            default: return CH_I;
        endcase
    endfunction

    function automatic logic [7:0] five_letter(input logic [1:0] g);
        case (g)
            2'd1:    return CH_D;
            2'd2:    return CH_L;
            default: return CH_V;
        endcase
    endfunction

    function automatic logic [7:0] ten_letter(input logic [1:0] g);
        case (g)
            2'd1:    return CH_M;
            2'd2:    return CH_C;
            default: return CH_X;
        endcase
    endfunction

    function automatic logic [11:0] group_weight(input logic [1:0] g);
        case (g)
            2'd0:    return 12'd1000;
            2'd1:    return 12'd100;
            2'd2:    return 12'd10;
            default: return 12'd1;
        endcase
    endfunction

    function automatic logic [7:0] random_letter();
        case ($urandom_range(6))
            0:       return CH_I;
            1:       return CH_V;
            2:       return CH_X;
            3:       return CH_L;
            4:       return CH_C;
            5:       return CH_D;
            default: return CH_M;
        endcase
    endfunction

    task automatic close_group();
        prs_group = prs_group + 3'd1;
        prs_five  = 1'b0;
        prs_ones  = '0;
    endtask

    // Greedy parse of one accepted character. A rejected character sets the
    // sticky error and leaves the group state as it was; once the error is
    // set the rest of the numeral is ignored. The final character pushes
    // the expected result and clears the parse state.
    task automatic parse_symbol(input rntb_in_t item);
        logic [2:0]  saved_group;
        logic        saved_five;
        logic [1:0]  saved_ones;
        logic [1:0]  g;
        logic [11:0] w;
        logic        started;
        logic        took;
        rntb_out_t   res;
        if (!prs_bad) begin
            saved_group = prs_group;
            saved_five  = prs_five;
            saved_ones  = prs_ones;
            took = 1'b0;
            while (!took && prs_group < GRP_CLOSED) begin
                g = prs_group[1:0];
                w = group_weight(g);
                started = prs_five || (prs_ones != 2'd0);
                if (g == 2'd0) begin
                    if (item.symbol == CH_M && prs_ones < 2'd3) begin
                        prs_ones  = prs_ones + 2'd1;
                        prs_total = prs_total + w;
                        took = 1'b1;
                    end
                end else if (!started && item.symbol == five_letter(g)) begin
                    prs_five  = 1'b1;
                    prs_total = prs_total + w * 12'd5;
                    took = 1'b1;
                end else if (item.symbol == one_letter(g) && prs_ones < 2'd3) begin
                    prs_ones  = prs_ones + 2'd1;
                    prs_total = prs_total + w;
                    took = 1'b1;
                end else if (prs_ones == 2'd1 && !prs_five
                             && item.symbol == five_letter(g)) begin
                    // Subtractive four closes the group.
                    prs_total = prs_total + w * 12'd3;
                    close_group();
                    took = 1'b1;
                end else if (prs_ones == 2'd1 && !prs_five
                             && item.symbol == ten_letter(g)) begin
                    // Subtractive nine closes the group.
                    prs_total = prs_total + w * 12'd8;
                    close_group();
                    took = 1'b1;
                end
                if (!took) begin
                    close_group();
                end
            end
            if (!took) begin
                prs_bad   = 1'b1;
                prs_group = saved_group;
                prs_five  = saved_five;
                prs_ones  = saved_ones;
            end
        end
        if (item.last_symbol) begin
            res.value       = prs_bad ? 12'd0 : prs_total;
            res.bad_numeral = prs_bad;
            expected_numerals.push_back(res);
            prs_group = '0;
            prs_five  = 1'b0;
            prs_ones  = '0;
            prs_total = '0;
            prs_bad   = 1'b0;
        end
    endtask

    // Driver: a new character is offered only once the previous transfer
    // has completed, so valid and payload hold steady while stalled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_symbols.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= pending_symbols.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever the stimulus
    // process asks for one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on every input transfer and check every result
    // transfer against the oldest prediction.
    always @(posedge aclk) begin
        rntb_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                parse_symbol(s_data);
            end
            if (m_valid && m_ready) begin
                if (expected_numerals.size() == 0) begin
                    $error("result transfer with no numeral pending: value %0d bad %0b",
                           m_data.value, m_data.bad_numeral);
                    fail_count++;
                end else begin
                    want = expected_numerals.pop_front();
                    if (m_data.value !== want.value) begin
                        $error("value mismatch: expected %0d, got %0d",
                               want.value, m_data.value);
                        fail_count++;
                    end
                    if (m_data.bad_numeral !== want.bad_numeral) begin
                        $error("bad_numeral mismatch: expected %0b, got %0b",
                               want.bad_numeral, m_data.bad_numeral);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Moves the numeral under construction into the pending queue, marking
    // its final character.
    task automatic emit_numeral();
        rntb_in_t item;
        for (int i = 0; i < numeral_buf.size(); i++) begin
            item.symbol      = numeral_buf[i];
            item.last_symbol = (i == numeral_buf.size() - 1);
            pending_symbols.push_back(item);
        end
        numeral_buf.delete();
    endtask

    task automatic emit_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            numeral_buf.push_back(txt[i]);
        end
        emit_numeral();
    endtask

    // Canonical spelling of n, 1..3999.
    task automatic spell_value(input int n);
        int d;
        for (int g = 0; g < 4; g++) begin
            d = (n / group_weight(g[1:0])) % 10;
            if (g == 0 || d < 4) begin
                repeat (d) numeral_buf.push_back(one_letter(g[1:0]));
            end else if (d == 4) begin
                numeral_buf.push_back(one_letter(g[1:0]));
                numeral_buf.push_back(five_letter(g[1:0]));
            end else if (d == 9) begin
                numeral_buf.push_back(one_letter(g[1:0]));
                numeral_buf.push_back(ten_letter(g[1:0]));
            end else begin
                numeral_buf.push_back(five_letter(g[1:0]));
                repeat (d - 5) numeral_buf.push_back(one_letter(g[1:0]));
            end
        end
    endtask

    // Random numerals until about count characters are queued. Most are
    // well formed; some have one character damaged or an extra letter
    // appended; the rest are short runs of letters and arbitrary bytes.
    task automatic queue_random(input int count);
        int queued;
        int r;
        int k;
        queued = 0;
        while (queued < count) begin
            r = $urandom_range(99);
            if (r < 85) begin
                if ($urandom_range(4) == 0) begin
                    spell_value($urandom_range(99, 1));
                end else begin
                    spell_value($urandom_range(3999, 1));
                end
                if (r >= 70) begin
                    k = $urandom_range(numeral_buf.size() - 1);
                    case ($urandom_range(2))
                        0:       numeral_buf[k] = random_letter();
                        1:       numeral_buf.push_back(random_letter());
                        default: numeral_buf[k] = 8'($urandom_range(255));
                    endcase
                end
            end else begin
                repeat ($urandom_range(5, 1)) begin
                    if ($urandom_range(1) == 0) begin
                        numeral_buf.push_back(8'($urandom_range(255)));
                    end else begin
                        numeral_buf.push_back(random_letter());
                    end
                end
            end
            queued += numeral_buf.size();
            emit_numeral();
        end
    endtask

    // Holds the sender back until every queued character has been taken
    // and every predicted result has come out.
    task automatic drain_all();
        while (pending_symbols.size() != 0 || s_valid || expected_numerals.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    // Stimulus sequencing. All updates to shared queues and knobs happen on
    // the falling edge so the clocked blocks never race them.
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed numerals: the largest value with every subtractive nine,
        // every subtractive four, too many thousands, the extreme byte codes
        // and a rejected letter followed by an ignored one.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        emit_text("MMMCMXCIX");
        emit_text("CDXLIV");
        emit_text("MMMM");
        numeral_buf.push_back(8'h00);
        emit_numeral();
        numeral_buf.push_back(8'hFF);
        emit_numeral();
        emit_text("QI");
        emit_text("IX");
        drain_all();

        // No idling; the receiver holds off for a long stretch while the
        // sender keeps offering, so the block backs up and stalls its input.
        queue_random(150);
        hold_requests = hold_requests + 1;
        queue_random(150);
        drain_all();

        // Idle sender, with a full pause in the middle.
        send_idle_pct = 52;
        queue_random(130);
        drain_all();
        queue_random(130);
        drain_all();

        // Stalling receiver, with another long hold-off.
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        queue_random(130);
        hold_requests = hold_requests + 1;
        queue_random(130);
        drain_all();

        // Light idling on both sides.
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        queue_random(260);
        drain_all();

        if (fail_count == 0 && expected_numerals.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
